/* hdl/msw_pkg.sv */
package msw_pkg;

	// Axis sample width used for the motion measure (8 to 16)
	localparam int unsigned SAMPLE_WIDTH = 16;
	localparam int unsigned AXIS_W       = 16;
	localparam int unsigned SUM_W        = SAMPLE_WIDTH + 1;
	localparam int unsigned MOTION_W     = 17;
	localparam int unsigned ELAPSED_W    = 16;
	localparam int unsigned THRESH_W     = 17;
	localparam int unsigned TIME_W       = 24;

	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	// Register indices (byte address = 4 * index)
	localparam logic [1:0] REG_STILL   = 2'd0;
	localparam logic [1:0] REG_SHAKE   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	localparam logic [THRESH_W-1:0] STILL_RESET   = THRESH_W'(8);
	localparam logic [THRESH_W-1:0] SHAKE_RESET   = THRESH_W'(10);
	localparam logic [TIME_W-1:0]   TIMEOUT_RESET = TIME_W'(15000);

	typedef struct packed {
		logic [THRESH_W-1:0] still_threshold;
		logic [THRESH_W-1:0] shake_threshold;
		logic [TIME_W-1:0]   idle_limit;
	} cfg_t;

endpackage

/* hdl/msw_sample_if.sv */
interface msw_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [msw_pkg::AXIS_W-1:0]     accel_x;
	logic signed [msw_pkg::AXIS_W-1:0]     accel_y;
	logic signed [msw_pkg::AXIS_W-1:0]     accel_z;
	logic        [msw_pkg::ELAPSED_W-1:0]  elapsed_ms;

	modport source (output valid, accel_x, accel_y, accel_z, elapsed_ms, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, elapsed_ms, output ready);
endinterface

/* hdl/msw_result_if.sv */
interface msw_result_if;
	logic                             valid;
	logic                             ready;
	logic [msw_pkg::MOTION_W-1:0]     motion;
	logic [msw_pkg::TIME_W-1:0]       idle_time;
	logic                             is_asleep;
	logic                             sleep_event;
	logic                             wake_event;

	modport source (output valid, motion, idle_time, is_asleep, sleep_event, wake_event,
		input ready);
	modport sink   (input valid, motion, idle_time, is_asleep, sleep_event, wake_event,
		output ready);
endinterface

/* hdl/motion_idle_sleep_wake_core.sv */
// Channel | Dir | Fields                                               | Handshake
// sample  | in  | accel_x, accel_y, accel_z (s16), elapsed_ms (u16)    | valid/ready
// result  | out | motion (u17), idle_time (u24), is_asleep,            | valid/ready
//         |     | sleep_event, wake_event                              |
// apb     | cfg | still_threshold, shake_threshold, idle_limit         | psel/penable
//
// One sample per cycle sustained while result.ready stays high; a result passes
// through the input register, motion register and result register in that order.
// Asynchronous active-low reset clears the previous-sample flag, idle time,
// sleep state and all stage valids; registers return to 8 / 10 / 15000.
// Each stage moves when the one after it is empty or moving; up to three samples
// are held, and sample.ready drops once all three stages are full and
// result.ready is low.
module motion_idle_sleep_wake_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msw_pkg::PADDR_W-1:0]   paddr,
	input  logic [msw_pkg::PDATA_W-1:0]   pwdata,
	output logic [msw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	msw_sample_if.sink                    sample,
	msw_result_if.source                  result
);

	msw_pkg::cfg_t cfg;

	// stage occupancy
	logic s1_valid_q, s2_valid_q, out_valid_q;
	logic accept, adv2, adv_out;

	logic [msw_pkg::MOTION_W-1:0]  motion_s2;
	logic [msw_pkg::ELAPSED_W-1:0] elapsed_s2;

	assign adv_out      = s2_valid_q & (~out_valid_q | result.ready);
	assign adv2         = s1_valid_q & (~s2_valid_q | adv_out);
	assign sample.ready = ~s1_valid_q | adv2;
	assign accept       = sample.valid & sample.ready;
	assign result.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s1_valid_q  <= accept | (s1_valid_q & ~adv2);
			s2_valid_q  <= adv2 | (s2_valid_q & ~adv_out);
			out_valid_q <= adv_out | (out_valid_q & ~result.ready);
		end
	end

	msw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// wrapped axis differences -> motion
	msw_motion u_motion (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_s1    (accept),
		.load_s2    (adv2),
		.accel_x    (sample.accel_x),
		.accel_y    (sample.accel_y),
		.accel_z    (sample.accel_z),
		.elapsed_ms (sample.elapsed_ms),
		.motion_s2  (motion_s2),
		.elapsed_s2 (elapsed_s2)
	);

	// idle accumulation and sleep / wake decision, updated in result order
	msw_idle u_idle (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv_out),
		.cfg           (cfg),
		.motion_s2     (motion_s2),
		.elapsed_s2    (elapsed_s2),
		.motion_q      (result.motion),
		.idle_time_q   (result.idle_time),
		.is_asleep_q   (result.is_asleep),
		.sleep_event_q (result.sleep_event),
		.wake_event_q  (result.wake_event)
	);

endmodule

/* hdl/msw_regs.sv */
module msw_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [msw_pkg::PADDR_W-1:0]   paddr,
	input  logic [msw_pkg::PDATA_W-1:0]   pwdata,
	output logic [msw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output msw_pkg::cfg_t                 cfg
);

	msw_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.still_threshold <= msw_pkg::STILL_RESET;
			cfg_q.shake_threshold <= msw_pkg::SHAKE_RESET;
			cfg_q.idle_limit      <= msw_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				msw_pkg::REG_STILL:   cfg_q.still_threshold <= pwdata[msw_pkg::THRESH_W-1:0];
				msw_pkg::REG_SHAKE:   cfg_q.shake_threshold <= pwdata[msw_pkg::THRESH_W-1:0];
				msw_pkg::REG_TIMEOUT: cfg_q.idle_limit      <= pwdata[msw_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			msw_pkg::REG_STILL:   prdata = msw_pkg::PDATA_W'(cfg_q.still_threshold);
			msw_pkg::REG_SHAKE:   prdata = msw_pkg::PDATA_W'(cfg_q.shake_threshold);
			msw_pkg::REG_TIMEOUT: prdata = msw_pkg::PDATA_W'(cfg_q.idle_limit);
			default:              prdata = '0;
		endcase
	end

endmodule

/* hdl/msw_motion.sv */
module msw_motion (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load_s1,
	input  logic                              load_s2,
	input  logic [msw_pkg::AXIS_W-1:0]        accel_x,
	input  logic [msw_pkg::AXIS_W-1:0]        accel_y,
	input  logic [msw_pkg::AXIS_W-1:0]        accel_z,
	input  logic [msw_pkg::ELAPSED_W-1:0]     elapsed_ms,
	output logic [msw_pkg::MOTION_W-1:0]      motion_s2,
	output logic [msw_pkg::ELAPSED_W-1:0]     elapsed_s2
);

	localparam int unsigned SW = msw_pkg::SAMPLE_WIDTH;

	// previous accepted sample, kept at accept time
	logic [SW-1:0] last_x_q, last_y_q, last_z_q;
	logic          have_last_q;

	logic [SW-1:0] cur_x_s1, cur_y_s1, cur_z_s1;
	logic [SW-1:0] prv_x_s1, prv_y_s1, prv_z_s1;
	logic          first_s1;
	logic [msw_pkg::ELAPSED_W-1:0] elapsed_s1;

	logic [SW-1:0]             ax, ay, az;
	logic [msw_pkg::SUM_W-1:0] sum;

	// |wrapped difference|; the most negative value negates to itself,
	// which read unsigned is 2^(SW-1)
	function automatic logic [SW-1:0] abs_diff(input logic [SW-1:0] cur,
		input logic [SW-1:0] prv);
		logic [SW-1:0] d;
		d = cur - prv;
		return d[SW-1] ? (~d + 1'b1) : d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_z_q    <= '0;
			have_last_q <= 1'b0;
		end else if (load_s1) begin
			last_x_q    <= accel_x[SW-1:0];
			last_y_q    <= accel_y[SW-1:0];
			last_z_q    <= accel_z[SW-1:0];
			have_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cur_x_s1   <= accel_x[SW-1:0];
			cur_y_s1   <= accel_y[SW-1:0];
			cur_z_s1   <= accel_z[SW-1:0];
			prv_x_s1   <= last_x_q;
			prv_y_s1   <= last_y_q;
			prv_z_s1   <= last_z_q;
			first_s1   <= ~have_last_q;
			elapsed_s1 <= elapsed_ms;
		end
	end

	always_comb begin
		ax  = abs_diff(cur_x_s1, prv_x_s1);
		ay  = abs_diff(cur_y_s1, prv_y_s1);
		az  = abs_diff(cur_z_s1, prv_z_s1);
		sum = msw_pkg::SUM_W'(ax) + msw_pkg::SUM_W'(ay) + msw_pkg::SUM_W'(az);
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			motion_s2  <= first_s1 ? '0 : msw_pkg::MOTION_W'(sum);
			elapsed_s2 <= elapsed_s1;
		end
	end

endmodule

/* hdl/msw_idle.sv */
module msw_idle (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  msw_pkg::cfg_t                 cfg,
	input  logic [msw_pkg::MOTION_W-1:0]  motion_s2,
	input  logic [msw_pkg::ELAPSED_W-1:0] elapsed_s2,
	output logic [msw_pkg::MOTION_W-1:0]  motion_q,
	output logic [msw_pkg::TIME_W-1:0]    idle_time_q,
	output logic                          is_asleep_q,
	output logic                          sleep_event_q,
	output logic                          wake_event_q
);

	localparam int unsigned TW = msw_pkg::TIME_W;

	logic [TW-1:0] idle_q;
	logic          asleep_q;

	logic [msw_pkg::ELAPSED_W-1:0] el;
	logic [TW:0]   acc_sum;
	logic [TW-1:0] acc, idle_nx;
	logic          asleep_nx, sev, wev;

	always_comb begin
		el      = (elapsed_s2 == '0) ? msw_pkg::ELAPSED_W'(1) : elapsed_s2;
		acc_sum = {1'b0, idle_q} + (TW+1)'(el);
		if (motion_s2 < msw_pkg::MOTION_W'(cfg.still_threshold)) begin
			acc = (acc_sum > (TW+1)'(cfg.idle_limit)) ? cfg.idle_limit
				: acc_sum[TW-1:0];
		end else begin
			acc = '0;
		end
		idle_nx   = idle_q;
		asleep_nx = asleep_q;
		sev       = 1'b0;
		wev       = 1'b0;
		if (!asleep_q) begin
			idle_nx = acc;
			if (acc >= cfg.idle_limit) begin
				asleep_nx = 1'b1;
				idle_nx   = '0;
				sev       = 1'b1;
			end
		end else if (motion_s2 >= msw_pkg::MOTION_W'(cfg.shake_threshold)) begin
			asleep_nx = 1'b0;
			idle_nx   = '0;
			wev       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q   <= '0;
			asleep_q <= 1'b0;
		end else if (load) begin
			idle_q   <= idle_nx;
			asleep_q <= asleep_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			motion_q      <= motion_s2;
			idle_time_q   <= idle_nx;
			is_asleep_q   <= asleep_nx;
			sleep_event_q <= sev;
			wake_event_q  <= wev;
		end
	end

endmodule

/* verif/msw_outcome_check.sv */
`timescale 1ns / 1ps
module msw_outcome_check
	import msw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic                pready,
	msw_sample_if               smp,
	msw_result_if               res,
	output int unsigned         errors,
	output int unsigned         pending
);

	typedef struct packed {
		logic [MOTION_W-1:0] motion;
		logic [TIME_W-1:0]   idle_time;
		logic                is_asleep;
		logic                sleep_event;
		logic                wake_event;
	} outcome_t;

	cfg_t                    cfg;
	logic [SAMPLE_WIDTH-1:0] prev_x;
	logic [SAMPLE_WIDTH-1:0] prev_y;
	logic [SAMPLE_WIDTH-1:0] prev_z;
	logic                    have_prev;
	logic [TIME_W-1:0]       idle_acc;
	logic                    sleeping;
	outcome_t                outcome_q[$];
	int unsigned             shown;

	// magnitude of a wrapped axis difference; the most negative one maps to 2^(W-1)
	function automatic logic [SAMPLE_WIDTH:0] axis_swing(input logic [SAMPLE_WIDTH-1:0] cur,
			input logic [SAMPLE_WIDTH-1:0] prev);
		logic [SAMPLE_WIDTH-1:0] d;
		logic [SAMPLE_WIDTH-1:0] m;
		d = cur - prev;
		m = ~d + 1'b1;
		return d[SAMPLE_WIDTH-1] ? {1'b0, m} : {1'b0, d};
	endfunction

	task automatic predict_outcome(input logic [AXIS_W-1:0] ax, input logic [AXIS_W-1:0] ay,
			input logic [AXIS_W-1:0] az, input logic [ELAPSED_W-1:0] el);
		logic [SAMPLE_WIDTH-1:0] x;
		logic [SAMPLE_WIDTH-1:0] y;
		logic [SAMPLE_WIDTH-1:0] z;
		logic [SAMPLE_WIDTH+2:0] swing;
		logic [ELAPSED_W-1:0]    step_ms;
		logic [TIME_W:0]         acc;
		outcome_t                o;
		x = ax[SAMPLE_WIDTH-1:0];
		y = ay[SAMPLE_WIDTH-1:0];
		z = az[SAMPLE_WIDTH-1:0];
		swing = '0;
		if (have_prev)
			swing = (SAMPLE_WIDTH+3)'(axis_swing(x, prev_x))
				+ (SAMPLE_WIDTH+3)'(axis_swing(y, prev_y))
				+ (SAMPLE_WIDTH+3)'(axis_swing(z, prev_z));
		prev_x = x;
		prev_y = y;
		prev_z = z;
		have_prev = 1'b1;
		o = '0;
		if (!sleeping) begin
			step_ms = (el == '0) ? ELAPSED_W'(1) : el;
			if (swing < (SAMPLE_WIDTH+3)'(cfg.still_threshold)) begin
				acc = {1'b0, idle_acc} + (TIME_W+1)'(step_ms);
				if (acc > {1'b0, cfg.idle_limit})
					acc = {1'b0, cfg.idle_limit};
				idle_acc = acc[TIME_W-1:0];
			end else begin
				idle_acc = '0;
			end
			if (idle_acc >= cfg.idle_limit) begin
				sleeping = 1'b1;
				idle_acc = '0;
				o.sleep_event = 1'b1;
			end
		end else if (swing >= (SAMPLE_WIDTH+3)'(cfg.shake_threshold)) begin
			sleeping = 1'b0;
			idle_acc = '0;
			o.wake_event = 1'b1;
		end
		o.motion = swing[MOTION_W-1:0];
		o.idle_time = idle_acc;
		o.is_asleep = sleeping;
		outcome_q.push_back(o);
	endtask

	task automatic check_outcome();
		outcome_t got;
		outcome_t want;
		got = {res.motion, res.idle_time, res.is_asleep, res.sleep_event, res.wake_event};
		if (outcome_q.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("%0t: result transfer with nothing outstanding, motion %0d idle %0d",
					$realtime, got.motion, got.idle_time);
			end
		end else begin
			want = outcome_q.pop_front();
			if (got !== want) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("%0t: mismatch (exp/got) motion %0d/%0d idle %0d/%0d asleep %b/%b",
						$realtime, want.motion, got.motion, want.idle_time, got.idle_time,
						want.is_asleep, got.is_asleep);
					$display("    sleep_event %b/%b wake_event %b/%b",
						want.sleep_event, got.sleep_event, want.wake_event, got.wake_event);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.still_threshold = STILL_RESET;
			cfg.shake_threshold = SHAKE_RESET;
			cfg.idle_limit = TIMEOUT_RESET;
			prev_x = '0;
			prev_y = '0;
			prev_z = '0;
			have_prev = 1'b0;
			idle_acc = '0;
			sleeping = 1'b0;
			outcome_q.delete();
			shown = 0;
			errors = 0;
			pending = 0;
		end else begin
			if (res.valid && res.ready)
				check_outcome();
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_STILL:   cfg.still_threshold = pwdata[THRESH_W-1:0];
					REG_SHAKE:   cfg.shake_threshold = pwdata[THRESH_W-1:0];
					REG_TIMEOUT: cfg.idle_limit = pwdata[TIME_W-1:0];
					default: ;
				endcase
			end
			if (smp.valid && smp.ready)
				predict_outcome(smp.accel_x, smp.accel_y, smp.accel_z, smp.elapsed_ms);
			pending = outcome_q.size();
		end
	end

endmodule

/* verif/tb_motion_idle_sleep_wake_core.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the sleep/wake detector. Prediction and comparison
// live in msw_outcome_check, which watches both channels and the register bus.
module tb_motion_idle_sleep_wake_core;
	import msw_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transfer at all
	localparam int unsigned HOLD_CYCLES = 300;   // long result back-pressure
	localparam int unsigned PHASES      = 10;
	localparam int unsigned PHASE_ITEMS = 168;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int unsigned        errors;
	int unsigned        pending;
	int unsigned        quiet_cycles;

	// last sample offered, so still and shake sequences can drift from it
	logic [AXIS_W-1:0]  cur_x;
	logic [AXIS_W-1:0]  cur_y;
	logic [AXIS_W-1:0]  cur_z;

	bit                 tx_steady;   // sender offers back to back
	bit                 rx_steady;   // receiver never stalls
	bit                 hold_req;    // ask the receiver for one long stall
	bit                 hold_taken;

	msw_sample_if smp ();
	msw_result_if res ();

	motion_idle_sleep_wake_core dut (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.sample (smp),
		.result (res)
	);

	msw_outcome_check outcome_check (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.pready,
		.smp,
		.res,
		.errors,
		.pending
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [AXIS_W-1:0] axis_corner();
		case ($urandom_range(0, 3))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// thresholds: mostly small so drift counts as still and jumps as shakes
	function automatic logic [THRESH_W-1:0] pick_threshold();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return THRESH_W'($urandom);
			default: return THRESH_W'($urandom_range(1, 40));
		endcase
	endfunction

	// timeouts: mostly short so sleep is reached within a handful of still samples
	function automatic logic [TIME_W-1:0] pick_timeout();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return TIME_W'($urandom);
			3:       return TIME_W'($urandom_range(1, 60000));
			default: return TIME_W'($urandom_range(1, 4000));
		endcase
	endfunction

	// Result side: ready is raised, then a random stall unless rx_steady is set. One long
	// stall on request, counted here, so the pipe fills and sample.ready drops.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				res.ready <= 1'b0;
				stall_left--;
			end else begin
				res.ready <= 1'b1;
				if (!rx_steady)
					stall_left = gap_len();
			end
		end
	end

	// Watchdog: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_motion_idle_sleep_wake_core: errors");
			$finish;
		end
	end

	// Offer one sample and hold it until the transfer; called at a rising edge.
	// valid is left high unless a gap follows, so back-to-back items get one
	// assignment per edge.
	task automatic put_sample(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
			input logic [AXIS_W-1:0] z, input logic [ELAPSED_W-1:0] el);
		int unsigned gap;
		smp.valid      <= 1'b1;
		smp.accel_x    <= x;
		smp.accel_y    <= y;
		smp.accel_z    <= z;
		smp.elapsed_ms <= el;
		cur_x = x;
		cur_y = y;
		cur_z = z;
		do @(posedge clk); while (!smp.ready);
		gap = tx_steady ? 0 : gap_len();
		if (gap != 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted result has been taken.
	task automatic drain_all();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Setup then access; psel is kept high into the next write's setup.
	task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Registers only change with the pipe empty.
	task automatic set_config(input logic [THRESH_W-1:0] still, input logic [THRESH_W-1:0] shake,
			input logic [TIME_W-1:0] timeout);
		drain_all();
		reg_write(REG_STILL, PDATA_W'(still));
		reg_write(REG_SHAKE, PDATA_W'(shake));
		reg_write(REG_TIMEOUT, PDATA_W'(timeout));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mostly small drift (still runs that reach sleep), then jumps that wake,
	// plus fully random samples and rail values.
	task automatic send_random();
		logic [AXIS_W-1:0]    nx;
		logic [AXIS_W-1:0]    ny;
		logic [AXIS_W-1:0]    nz;
		logic [ELAPSED_W-1:0] el;
		int unsigned          kind;
		int unsigned          pick;
		kind = $urandom_range(0, 99);
		if (kind < 55) begin
			nx = cur_x + AXIS_W'($urandom_range(0, 4)) - AXIS_W'(2);
			ny = cur_y + AXIS_W'($urandom_range(0, 4)) - AXIS_W'(2);
			nz = cur_z + AXIS_W'($urandom_range(0, 4)) - AXIS_W'(2);
		end else if (kind < 75) begin
			nx = cur_x + AXIS_W'($urandom_range(0, 8000)) - AXIS_W'(4000);
			ny = cur_y + AXIS_W'($urandom_range(0, 8000)) - AXIS_W'(4000);
			nz = cur_z + AXIS_W'($urandom_range(0, 8000)) - AXIS_W'(4000);
		end else if (kind < 90) begin
			nx = AXIS_W'($urandom);
			ny = AXIS_W'($urandom);
			nz = AXIS_W'($urandom);
		end else begin
			nx = axis_corner();
			ny = axis_corner();
			nz = axis_corner();
		end
		pick = $urandom_range(0, 99);
		if (pick < 10)
			el = '0;
		else if (pick < 15)
			el = '1;
		else if (pick < 55)
			el = ELAPSED_W'($urandom_range(1, 50));
		else if (pick < 85)
			el = ELAPSED_W'($urandom_range(1, 2000));
		else
			el = ELAPSED_W'($urandom);
		put_sample(nx, ny, nz, el);
	endtask

	initial begin
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		smp.valid      <= 1'b0;
		smp.accel_x    <= '0;
		smp.accel_y    <= '0;
		smp.accel_z    <= '0;
		smp.elapsed_ms <= '0;
		quiet_cycles   <= 0;
		cur_x = '0;
		cur_y = '0;
		cur_z = '0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		hold_req = 1'b0;
		hold_taken = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed, reset config 8 / 10 / 15000 ---
		// first sample gives zero motion; zero elapsed counts as one
		put_sample(16'h8000, 16'h7FFF, 16'h0000, 16'h0000);
		// full-scale wraps give tiny motion; max elapsed saturates -> sleep
		put_sample(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
		// most negative wrapped difference -> 32768, wakes
		put_sample(16'hFFFF, 16'h8000, 16'hFFFF, 16'h0005);
		put_sample(16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000);
		// motion equal to the still threshold is not still
		put_sample(16'h0007, 16'h8000, 16'hFFFF, 16'd100);
		put_sample(16'h000E, 16'h8000, 16'hFFFF, 16'd100);

		// zero timeout: every awake step sleeps; shake boundary either side
		set_config(THRESH_W'(8), THRESH_W'(10), '0);
		put_sample(16'h000E, 16'h8000, 16'hFFFF, 16'h0000);
		put_sample(16'h0017, 16'h8000, 16'hFFFF, 16'd40);
		put_sample(16'h0021, 16'h8000, 16'hFFFF, 16'd40);
		put_sample(16'h0021, 16'h8000, 16'hFFFF, 16'd40);

		// zero thresholds: zero motion wakes, nothing counts as still
		set_config('0, '0, '1);
		put_sample(16'h0021, 16'h8000, 16'hFFFF, 16'd3);
		put_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);

		// top thresholds: largest motion is still and never wakes
		set_config('1, '1, TIME_W'(1000));
		put_sample(16'h8000, 16'h8000, 16'h8000, 16'd600);
		put_sample(16'h0000, 16'h0000, 16'h0000, 16'd500);
		put_sample(16'h8000, 16'h8000, 16'h8000, 16'd500);

		set_config('1, THRESH_W'(10), TIME_W'(1000));
		put_sample(16'h0000, 16'h0000, 16'h0000, 16'd7);
		put_sample(16'h0000, 16'h0000, 16'h0000, 16'd900);

		// timeout lowered under the held idle time: next still step saturates
		set_config('1, THRESH_W'(10), TIME_W'(500));
		put_sample(16'h0001, 16'h0000, 16'h0000, 16'd1);

		// --- random phases, fresh register settings each ---
		for (int p = 0; p < PHASES; p++) begin
			set_config(pick_threshold(), pick_threshold(), pick_timeout());
			// phase 2: long receiver hold while samples keep coming
			// phase 4: no idling on either side
			tx_steady = (p == 2) || (p == 4);
			rx_steady = (p == 4);
			if (p == 2)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// sender pauses mid phase until the pipe has emptied
				if (p == 6 && i == PHASE_ITEMS / 2)
					drain_all();
				send_random();
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		drain_all();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_motion_idle_sleep_wake_core: clean");
		else
			$display("tb_motion_idle_sleep_wake_core: errors");
		$finish;
	end

endmodule
